// ===== hw/rtl/udft_pkg.sv =====
// shared types for the uv differential solver
package udft_pkg;

  // projection plane code, also the value of plane_used
  typedef enum logic [1:0] {
    PLANE_XY   = 2'd0,
    PLANE_XZ   = 2'd1,
    PLANE_YZ   = 2'd2,
    PLANE_NONE = 2'd3
  } plane_t;

  // plane choice carried down the pipeline
  typedef struct packed {
    logic   solved;
    plane_t plane;
  } pick_t;

endpackage

// ===== hw/rtl/udft_det.sv =====
// tangent determinants, plane pick and operand select (four stages)
module udft_det import udft_pkg::*; #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [W-1:0] p_in [3],
  input  logic signed [W-1:0] u_in [3],
  input  logic signed [W-1:0] v_in [3],
  output logic                out_valid,
  output pick_t               pick,
  output logic signed [W-1:0] pi,
  output logic signed [W-1:0] pj,
  output logic signed [W-1:0] ui,
  output logic signed [W-1:0] uj,
  output logic signed [W-1:0] vi,
  output logic signed [W-1:0] vj,
  output logic signed [2*W:0] den
);

  localparam int PW = 2 * W;
  localparam int DW = 2 * W + 1;
  localparam int MW = 2 * W;

  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;

  logic signed [W-1:0]  p1_r [3], u1_r [3], v1_r [3];
  logic signed [PW-1:0] pa1_r [3], pb1_r [3];
  logic signed [W-1:0]  p2_r [3], u2_r [3], v2_r [3];
  logic signed [DW-1:0] det2_r [3];
  logic signed [W-1:0]  p3_r [3], u3_r [3], v3_r [3];
  logic signed [DW-1:0] det3_r [3];
  logic [MW-1:0]        mag3_r [3];

  pick_t               pick_nxt, pick_r;
  logic signed [W-1:0] pi_nxt, pj_nxt, ui_nxt, uj_nxt, vi_nxt, vj_nxt;
  logic signed [W-1:0] pi_r, pj_r, ui_r, uj_r, vi_r, vj_r;
  logic signed [DW-1:0] den_nxt, den_r;
  logic win0, win1, win2;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  // stage 1 products, stage 2 differences, stage 3 magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= p_in;
      u1_r <= u_in;
      v1_r <= v_in;
      // xy: planes (0,1), xz: (0,2), yz: (1,2)
      pa1_r[0] <= PW'(u_in[0]) * PW'(v_in[1]);
      pb1_r[0] <= PW'(v_in[0]) * PW'(u_in[1]);
      pa1_r[1] <= PW'(u_in[0]) * PW'(v_in[2]);
      pb1_r[1] <= PW'(v_in[0]) * PW'(u_in[2]);
      pa1_r[2] <= PW'(u_in[1]) * PW'(v_in[2]);
      pb1_r[2] <= PW'(v_in[1]) * PW'(u_in[2]);

      p2_r <= p1_r;
      u2_r <= u1_r;
      v2_r <= v1_r;
      for (int k = 0; k < 3; k++) begin
        det2_r[k] <= DW'(pa1_r[k]) - DW'(pb1_r[k]);
      end

      p3_r   <= p2_r;
      u3_r   <= u2_r;
      v3_r   <= v2_r;
      det3_r <= det2_r;
      for (int k = 0; k < 3; k++) begin
        mag3_r[k] <= det2_r[k][DW-1] ? MW'(-det2_r[k]) : MW'(det2_r[k]);
      end
    end
  end

  // strictly largest nonzero magnitude wins, xy tested first
  always_comb begin
    win0 = (mag3_r[0] != '0) && (mag3_r[0] > mag3_r[1]) && (mag3_r[0] > mag3_r[2]);
    win1 = (mag3_r[1] != '0) && (mag3_r[1] > mag3_r[2]) && (mag3_r[1] > mag3_r[0]);
    win2 = (mag3_r[2] != '0) && (mag3_r[2] > mag3_r[0]) && (mag3_r[2] > mag3_r[1]);
    if (win0) begin
      pick_nxt = '{solved: 1'b1, plane: PLANE_XY};
    end else if (win1) begin
      pick_nxt = '{solved: 1'b1, plane: PLANE_XZ};
    end else if (win2) begin
      pick_nxt = '{solved: 1'b1, plane: PLANE_YZ};
    end else begin
      pick_nxt = '{solved: 1'b0, plane: PLANE_NONE};
    end
  end

  // operand select for the chosen plane
  always_comb begin
    case (pick_nxt.plane)
      PLANE_XZ: begin
        pi_nxt = p3_r[0]; pj_nxt = p3_r[2];
        ui_nxt = u3_r[0]; uj_nxt = u3_r[2];
        vi_nxt = v3_r[0]; vj_nxt = v3_r[2];
        den_nxt = det3_r[1];
      end
      PLANE_YZ: begin
        pi_nxt = p3_r[1]; pj_nxt = p3_r[2];
        ui_nxt = u3_r[1]; uj_nxt = u3_r[2];
        vi_nxt = v3_r[1]; vj_nxt = v3_r[2];
        den_nxt = det3_r[2];
      end
      PLANE_XY: begin
        pi_nxt = p3_r[0]; pj_nxt = p3_r[1];
        ui_nxt = u3_r[0]; uj_nxt = u3_r[1];
        vi_nxt = v3_r[0]; vj_nxt = v3_r[1];
        den_nxt = det3_r[0];
      end
      default: begin
        pi_nxt = p3_r[0]; pj_nxt = p3_r[1];
        ui_nxt = u3_r[0]; uj_nxt = u3_r[1];
        vi_nxt = v3_r[0]; vj_nxt = v3_r[1];
        den_nxt = '0;
      end
    endcase
  end

  // stage 4 register
  always_ff @(posedge clk) begin
    if (en) begin
      pick_r <= pick_nxt;
      pi_r   <= pi_nxt;
      pj_r   <= pj_nxt;
      ui_r   <= ui_nxt;
      uj_r   <= uj_nxt;
      vi_r   <= vi_nxt;
      vj_r   <= vj_nxt;
      den_r  <= den_nxt;
    end
  end

  assign out_valid = s4_valid_r;
  assign pick      = pick_r;
  assign pi        = pi_r;
  assign pj        = pj_r;
  assign ui        = ui_r;
  assign uj        = uj_r;
  assign vi        = vi_r;
  assign vj        = vj_r;
  assign den       = den_r;

endmodule

// ===== hw/rtl/udft_numer.sv =====
// cramer numerators and magnitudes (three stages)
module udft_numer import udft_pkg::*; #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  pick_t               in_pick,
  input  logic signed [W-1:0] pi,
  input  logic signed [W-1:0] pj,
  input  logic signed [W-1:0] ui,
  input  logic signed [W-1:0] uj,
  input  logic signed [W-1:0] vi,
  input  logic signed [W-1:0] vj,
  input  logic signed [2*W:0] den,
  output logic                out_valid,
  output pick_t               out_pick,
  output logic [2*W-1:0]      nmag [2],
  output logic [2*W-1:0]      dmag,
  output logic                neg [2]
);

  localparam int PW = 2 * W;
  localparam int DW = 2 * W + 1;
  localparam int MW = 2 * W;

  logic s5_valid_r, s6_valid_r, s7_valid_r;

  logic signed [PW-1:0] pa_u5_r, pb_u5_r, pa_v5_r, pb_v5_r;
  logic signed [DW-1:0] den5_r, den6_r;
  pick_t                pick5_r, pick6_r, pick7_r;
  logic signed [DW-1:0] nu6_r, nv6_r;
  logic [MW-1:0]        nmag7_r [2];
  logic [MW-1:0]        dmag7_r;
  logic                 neg7_r [2];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
      s7_valid_r <= 1'b0;
    end else if (en) begin
      s5_valid_r <= in_valid;
      s6_valid_r <= s5_valid_r;
      s7_valid_r <= s6_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // products: du = p_i*v_j - v_i*p_j, dv = u_i*p_j - p_i*u_j
      pa_u5_r <= PW'(pi) * PW'(vj);
      pb_u5_r <= PW'(vi) * PW'(pj);
      pa_v5_r <= PW'(ui) * PW'(pj);
      pb_v5_r <= PW'(pi) * PW'(uj);
      den5_r  <= den;
      pick5_r <= in_pick;

      // exact differences
      nu6_r   <= DW'(pa_u5_r) - DW'(pb_u5_r);
      nv6_r   <= DW'(pa_v5_r) - DW'(pb_v5_r);
      den6_r  <= den5_r;
      pick6_r <= pick5_r;

      // magnitudes and quotient signs
      nmag7_r[0] <= nu6_r[DW-1] ? MW'(-nu6_r) : MW'(nu6_r);
      nmag7_r[1] <= nv6_r[DW-1] ? MW'(-nv6_r) : MW'(nv6_r);
      dmag7_r    <= den6_r[DW-1] ? MW'(-den6_r) : MW'(den6_r);
      neg7_r[0]  <= nu6_r[DW-1] ^ den6_r[DW-1];
      neg7_r[1]  <= nv6_r[DW-1] ^ den6_r[DW-1];
      pick7_r    <= pick6_r;
    end
  end

  assign out_valid = s7_valid_r;
  assign out_pick  = pick7_r;
  assign nmag      = nmag7_r;
  assign dmag      = dmag7_r;
  assign neg       = neg7_r;

endmodule

// ===== hw/rtl/udft_divider.sv =====
// two-lane restoring divider, one quotient bit per stage
module udft_divider import udft_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  pick_t          in_pick,
  input  logic [2*W-1:0] nmag [2],
  input  logic [2*W-1:0] dmag,
  input  logic           in_neg [2],
  output logic           out_valid,
  output pick_t          out_pick,
  output logic [W-1:0]   quo [2],
  output logic           out_neg [2],
  output logic           ovf [2]
);

  localparam int MW = 2 * W;
  localparam int CW = 3 * W;

  logic          valid_r [W+1];
  pick_t         pick_r  [W+1];
  logic [CW-1:0] x_r     [W+1][2];
  logic [MW-1:0] d_r     [W+1];
  logic [W-1:0]  q_r     [W+1][2];
  logic          neg_r   [W+1][2];
  logic          ovf_r   [W+1][2];

  // entry stage: scale numerator, flag quotients that do not fit in W bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pick_r[0] <= in_pick;
      d_r[0]    <= dmag;
      for (int l = 0; l < 2; l++) begin
        x_r[0][l]   <= CW'(nmag[l]) << F;
        q_r[0][l]   <= '0;
        neg_r[0][l] <= in_neg[l];
        ovf_r[0][l] <= (CW'(nmag[l]) << F) >= (CW'(dmag) << W);
      end
    end
  end

  // one compare-subtract per stage, msb first
  for (genvar s = 1; s <= W; s++) begin : g_step
    localparam int K = W - s;
    logic [CW-1:0] dsh [2];
    logic          ge  [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        dsh[l] = CW'(d_r[s-1]) << K;
        ge[l]  = x_r[s-1][l] >= dsh[l];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= valid_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pick_r[s] <= pick_r[s-1];
        d_r[s]    <= d_r[s-1];
        for (int l = 0; l < 2; l++) begin
          x_r[s][l]   <= ge[l] ? (x_r[s-1][l] - dsh[l]) : x_r[s-1][l];
          q_r[s][l]   <= q_r[s-1][l] | (W'(ge[l]) << K);
          neg_r[s][l] <= neg_r[s-1][l];
          ovf_r[s][l] <= ovf_r[s-1][l];
        end
      end
    end
  end

  assign out_valid = valid_r[W];
  assign out_pick  = pick_r[W];
  assign quo       = q_r[W];
  assign out_neg   = neg_r[W];
  assign ovf       = ovf_r[W];

endmodule

// ===== hw/rtl/uv_differentials_from_tangents.sv =====
// uv differentials from surface tangents: top level
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata: offset xyz, tangent_u xyz, tangent_v xyz
//  out_    | out | out_tvalid/out_tready| out_tdata: delta_u, delta_v; out_tuser: solved, plane
//
// one item per cycle while out_tready does not hold the pipeline; the divider
// resolves one quotient bit per stage
// reset clears only the valid bits; no clearing pass, no state between items
// the whole pipeline advances together; out_tready low holds every stage while the output register is full
module uv_differentials_from_tangents import udft_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // offset_x, offset_y, offset_z, tangent_u_x..z, tangent_v_x..z, lowest first
  input  logic [((9*VALUE_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // delta_u, delta_v, lowest first
  output logic [((2*VALUE_WIDTH+7)/8)*8-1:0] out_tdata,
  // solved, plane_used[1:0], lowest first
  output logic [2:0] out_tuser
);

  localparam int W   = VALUE_WIDTH;
  localparam int MW  = 2 * W;
  localparam int ODW = ((2 * W + 7) / 8) * 8;

  logic en;

  logic signed [W-1:0] p_in [3], u_in [3], v_in [3];

  logic                d_valid;
  pick_t               d_pick;
  logic signed [W-1:0] pi, pj, ui, uj, vi, vj;
  logic signed [2*W:0] den;

  logic          n_valid;
  pick_t         n_pick;
  logic [MW-1:0] nmag [2];
  logic [MW-1:0] dmag;
  logic          n_neg [2];

  logic         q_valid;
  pick_t        q_pick;
  logic [W-1:0] quo [2];
  logic         q_neg [2];
  logic         q_ovf [2];

  logic [W-1:0] res_nxt [2];
  logic [W-1:0] lim [2];
  logic [W-1:0] mag [2];

  logic         out_valid_r;
  logic [W-1:0] du_r, dv_r;
  pick_t        pick_out_r;

  // global advance: output register empty or being taken
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // unpack the input transfer
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p_in[k] = in_tdata[k*W +: W];
      u_in[k] = in_tdata[(3+k)*W +: W];
      v_in[k] = in_tdata[(6+k)*W +: W];
    end
  end

  udft_det #(.W(W)) u_det (
    .clk, .rst_n, .en,
    .in_valid (in_tvalid),
    .p_in, .u_in, .v_in,
    .out_valid(d_valid),
    .pick     (d_pick),
    .pi, .pj, .ui, .uj, .vi, .vj,
    .den
  );

  udft_numer #(.W(W)) u_numer (
    .clk, .rst_n, .en,
    .in_valid (d_valid),
    .in_pick  (d_pick),
    .pi, .pj, .ui, .uj, .vi, .vj,
    .den,
    .out_valid(n_valid),
    .out_pick (n_pick),
    .nmag,
    .dmag,
    .neg      (n_neg)
  );

  udft_divider #(.W(W), .F(FRAC_BITS)) u_div (
    .clk, .rst_n, .en,
    .in_valid (n_valid),
    .in_pick  (n_pick),
    .nmag,
    .dmag,
    .in_neg   (n_neg),
    .out_valid(q_valid),
    .out_pick (q_pick),
    .quo,
    .out_neg  (q_neg),
    .ovf      (q_ovf)
  );

  // saturate, apply sign, zero when unsolved
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      lim[l] = q_neg[l] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
      mag[l] = (q_ovf[l] || (quo[l] > lim[l])) ? lim[l] : quo[l];
      if (!q_pick.solved) begin
        res_nxt[l] = '0;
      end else begin
        res_nxt[l] = q_neg[l] ? W'(-mag[l]) : mag[l];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      du_r       <= res_nxt[0];
      dv_r       <= res_nxt[1];
      pick_out_r <= q_pick;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = ODW'({dv_r, du_r});
  assign out_tuser  = {pick_out_r.plane, pick_out_r.solved};

  // unsolved results carry zero deltas
  a_unsolved_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !pick_out_r.solved) |-> (du_r == '0 && dv_r == '0))
    else $error("unsolved result with nonzero delta");

  // solved flag agrees with plane code
  a_plane_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (pick_out_r.solved == (pick_out_r.plane != PLANE_NONE)))
    else $error("solved flag and plane code disagree");

  // unsolved items reach the divider with a zero divisor
  a_div_den : assert property (@(posedge clk) disable iff (!rst_n)
    (n_valid && !n_pick.solved) |-> (dmag == '0))
    else $error("unsolved item with nonzero divisor");

endmodule

// ===== test/uv_differentials_from_tangents_test.sv =====
// testbench for the uv differential solver: random and directed vectors against a predictor
`timescale 1ns / 1ps

module uv_differentials_from_tangents_test;
  import udft_pkg::*;

  localparam int VW = 32;
  localparam int FB = 16;
  localparam int IN_W = ((9*VW+7)/8)*8;
  localparam int OUT_W = ((2*VW+7)/8)*8;
  localparam int LATENCY = VW + 9;

  typedef struct packed {
    logic signed [VW-1:0] dv;
    logic signed [VW-1:0] du;
    logic                 solved;
    plane_t               plane;
  } solution_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic [2:0] out_tuser;

  logic [IN_W-1:0] pending_vectors[$];
  solution_t expected_solutions[$];
  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;

  uv_differentials_from_tangents #(.VALUE_WIDTH(VW), .FRAC_BITS(FB)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // exact quotient (num << FB) / den toward zero, saturated
  function automatic logic signed [VW-1:0] saturated_quotient(
      logic signed [2*VW+1:0] num, logic signed [2*VW+1:0] den);
    logic signed [2*VW+FB+3:0] q;
    logic signed [2*VW+FB+3:0] hi;
    logic signed [2*VW+FB+3:0] lo;
    q = (($signed({{(FB+2){num[2*VW+1]}}, num})) <<< FB) /
        $signed({{(FB+2){den[2*VW+1]}}, den});
    hi = (1 <<< (VW-1)) - 1;
    lo = -(1 <<< (VW-1));
    if (q > hi) return hi[VW-1:0];
    if (q < lo) return lo[VW-1:0];
    return q[VW-1:0];
  endfunction

  // solve p = du*u + dv*v in the projection with the strictly largest determinant
  function automatic solution_t solve_uv(logic [IN_W-1:0] vec);
    logic signed [VW-1:0] p[3];
    logic signed [VW-1:0] u[3];
    logic signed [VW-1:0] v[3];
    logic signed [2*VW+1:0] det[3];
    logic [2*VW+1:0] mag[3];
    logic signed [2*VW+1:0] nu;
    logic signed [2*VW+1:0] nv;
    int ia[3];
    int ib[3];
    int pick;
    int i;
    int j;
    solution_t s;
    ia = '{0, 0, 1};
    ib = '{1, 2, 2};
    for (int k = 0; k < 3; k++) begin
      p[k] = vec[k*VW +: VW];
      u[k] = vec[(3+k)*VW +: VW];
      v[k] = vec[(6+k)*VW +: VW];
    end
    for (int k = 0; k < 3; k++) begin
      det[k] = 66'(u[ia[k]]) * 66'(v[ib[k]]) - 66'(v[ia[k]]) * 66'(u[ib[k]]);
      mag[k] = det[k] < 0 ? -det[k] : det[k];
    end
    pick = 3;
    for (int k = 0; k < 3 && pick == 3; k++)
      if (mag[k] != 0 && mag[k] > mag[(k+1)%3] && mag[k] > mag[(k+2)%3]) pick = k;
    if (pick == 3) begin
      s = '{dv: '0, du: '0, solved: 1'b0, plane: PLANE_NONE};
    end else begin
      i = ia[pick];
      j = ib[pick];
      nu = 66'(p[i]) * 66'(v[j]) - 66'(v[i]) * 66'(p[j]);
      nv = 66'(u[i]) * 66'(p[j]) - 66'(p[i]) * 66'(u[j]);
      s.du = saturated_quotient(nu, det[pick]);
      s.dv = saturated_quotient(nv, det[pick]);
      s.solved = 1'b1;
      s.plane = plane_t'(pick[1:0]);
    end
    return s;
  endfunction

  function automatic logic [VW-1:0] random_component(int mode);
    case (mode)
      0: return $urandom;
      1: return VW'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      2: return $urandom_range(0, 1) ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
      default: return VW'($signed($urandom_range(0, 6)) - 3);
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pack_vector(logic [VW-1:0] c[9]);
    logic [IN_W-1:0] d;
    d = '0;
    for (int k = 0; k < 9; k++) d[k*VW +: VW] = c[k];
    return d;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_vectors.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tdata <= pending_vectors[0];
        expected_solutions.push_back(solve_uv(pending_vectors.pop_front()));
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  // monitor
  always @(posedge clk) begin
    solution_t got;
    solution_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{dv: out_tdata[VW +: VW], du: out_tdata[0 +: VW],
              solved: out_tuser[0], plane: plane_t'(out_tuser[2:1])};
      if (expected_solutions.size() == 0) begin
        $error("unexpected transfer du=%h dv=%h", got.du, got.dv);
        errors++;
      end else begin
        want = expected_solutions.pop_front();
        if (got.du !== want.du) begin
          $error("delta_u expected %h actual %h", want.du, got.du);
          errors++;
        end
        if (got.dv !== want.dv) begin
          $error("delta_v expected %h actual %h", want.dv, got.dv);
          errors++;
        end
        if (got.solved !== want.solved) begin
          $error("solved expected %b actual %b", want.solved, got.solved);
          errors++;
        end
        if (got.plane !== want.plane) begin
          $error("plane_used expected %0d actual %0d", want.plane, got.plane);
          errors++;
        end
      end
    end
  end

  task automatic drain_stimulus();
    while (pending_vectors.size() > 0 || in_tvalid) @(posedge clk);
  endtask

  // stimulus and sequencing
  initial begin
    logic [VW-1:0] c[9];
    int mode;
    errors = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    hold_cycles = 0;
    send_idle_pct = 31;
    recv_idle_pct = 62;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: all zero, unit tangents in each plane, ties, extremes
    c = '{default: '0};
    pending_vectors.push_back(pack_vector(c));
    for (int k = 0; k < 3; k++) begin
      c = '{default: '0};
      c[0] = 32'h0003_0000; c[1] = 32'hFFFE_0000; c[2] = 32'h0001_8000;
      c[3 + (k == 2 ? 1 : 0)] = 32'h0001_0000;
      c[6 + (k == 0 ? 1 : 2)] = 32'h0001_0000;
      pending_vectors.push_back(pack_vector(c));
    end
    // xy ties with xz: u = (1,0,0) v = (0,1,1)
    c = '{default: '0};
    c[3] = 32'h0001_0000; c[7] = 32'h0001_0000; c[8] = 32'h0001_0000;
    pending_vectors.push_back(pack_vector(c));
    // extremes everywhere
    for (int k = 0; k < 8; k++) begin
      foreach (c[n]) c[n] = random_component(2);
      pending_vectors.push_back(pack_vector(c));
    end
    // tiny determinant with huge offset: saturation both ways
    c = '{default: '0};
    c[0] = 32'h7FFF_FFFF; c[1] = 32'h8000_0000; c[3] = 32'd1; c[7] = 32'd1;
    pending_vectors.push_back(pack_vector(c));
    c[3] = 32'hFFFF_FFFF;
    pending_vectors.push_back(pack_vector(c));
    // alternating bit patterns
    foreach (c[n]) c[n] = (n % 2) ? 32'hAAAA_AAAA : 32'h5555_5555;
    pending_vectors.push_back(pack_vector(c));
    foreach (c[n]) c[n] = (n % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA;
    pending_vectors.push_back(pack_vector(c));

    // random: mixed magnitudes, three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      for (int k = 0; k < 250; k++) begin
        mode = $urandom_range(0, 3);
        foreach (c[n]) c[n] = random_component($urandom_range(0, 3) == 0 ? 0 : mode);
        pending_vectors.push_back(pack_vector(c));
      end
      if (phase == 1) begin
        // long receiver hold-off while items keep arriving
        hold_cycles = 300;
      end
      drain_stimulus();
      if (phase == 0) begin
        send_idle_pct = 62;
        recv_idle_pct = 31;
      end else if (phase == 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end

    while (expected_solutions.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/udft_pkg.sv
hw/rtl/udft_det.sv
hw/rtl/udft_numer.sv
hw/rtl/udft_divider.sv
hw/rtl/uv_differentials_from_tangents.sv
test/uv_differentials_from_tangents_test.sv
